@@ design/fccm_pkg.sv @@
// Shared constants and types for the cluster chain manager.
// Used by fat_cluster_chain_manager_core and the testbench; depends on nothing.
`timescale 1ns / 1ps

package fccm_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned ENTRY_WIDTH = 16;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CFG_W       = ADDR_W + 1;

  localparam logic [ENTRY_WIDTH-1:0] END_OF_CHAIN = {ENTRY_WIDTH{1'b1}};
  localparam logic [ADDR_W-1:0]      FIRST_DATA   = ADDR_W'(2);
  localparam logic [CFG_W-1:0]       LAST_MIN     = CFG_W'(3);
  localparam logic [CFG_W-1:0]       LAST_MAX     = CFG_W'(TABLE_DEPTH);

  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [ENTRY_WIDTH-1:0] entry_t;
  typedef logic [CFG_W-1:0]       count_t;

  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_WRITE  = 2'd3
  } mode_e;

endpackage

@@ design/fccm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Read returns the old contents when both ports hit the same address; no package use.
`timescale 1ns / 1ps

module fccm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/fat_cluster_chain_manager_core.sv @@
// Top level of the cluster chain manager: link table in fccm_ram plus the sequencer.
// Depends on fccm_pkg and fccm_ram.
`timescale 1ns / 1ps

// The block keeps a table of next-cluster links and serves one command word at
// a time on the slave stream. tuser carries the mode (create, remove, read,
// write); tdata carries the cluster, the previous cluster and the entry value.
// Each command yields exactly one word on the master stream: the result cluster
// in tdata and the full status in tuser.
// Work per word: a write stores the entry; a read fetches it; create scans for
// a free entry, links the given cluster to it if that is nonzero and marks it as
// end of chain, or sets the status when no entry is free; remove frees each
// chain entry in turn, then marks the previous cluster if one is given. The
// single read and single write port of the link RAM set the pace: the scan
// and the chain walk touch one entry a cycle.
// After reset a clearing pass writes zero to all 4096 entries, one per cycle;
// no command is taken during that pass, while the configuration write
// port works throughout. The finished result sits in an output register, so a
// stalled receiver holds only that word; the next command is still taken and
// worked on, and it waits before its result only if the register is still full.
module fat_cluster_chain_manager_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [11:0] cluster, [23:12] prev_cluster, [39:24] entry_value
  input  logic [39:0] s_axis_tdata_i,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] result_cluster
  output logic [15:0] m_axis_tdata_o,
  // [0] status
  output logic [0:0]  m_axis_tuser_o
);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b00_0000_0001,
    S_IDLE    = 10'b00_0000_0010,
    S_SCAN    = 10'b00_0000_0100,
    S_LINK    = 10'b00_0000_1000,
    S_MARK    = 10'b00_0001_0000,
    S_RM_WALK = 10'b00_0010_0000,
    S_RM_PREV = 10'b00_0100_0000,
    S_READ    = 10'b00_1000_0000,
    S_DONE    = 10'b01_0000_0000,
    S_WRITE   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  fccm_pkg::count_t lc_q, lc_d;
  fccm_pkg::addr_t  scan_q, scan_d;
  fccm_pkg::addr_t  clr_q, clr_d;
  fccm_pkg::addr_t  iss_p_q, iss_p_d;
  fccm_pkg::count_t iss_cnt_q, iss_cnt_d;
  fccm_pkg::addr_t  chk_p_q, chk_p_d;
  logic             chk_vld_q, chk_vld_d;
  fccm_pkg::addr_t  p_q, p_d;
  fccm_pkg::addr_t  walk_q, walk_d;
  logic             fwd_q, fwd_d;
  fccm_pkg::addr_t  clst_q, clst_d;
  fccm_pkg::addr_t  pclst_q, pclst_d;
  fccm_pkg::entry_t res_q, res_d;
  logic             stat_q, stat_d;
  logic             mvalid_q, mvalid_d;
  fccm_pkg::entry_t mdata_q, mdata_d;
  logic             mstat_q, mstat_d;

  logic             ram_we, ram_re;
  fccm_pkg::addr_t  ram_waddr, ram_raddr;
  fccm_pkg::entry_t ram_wdata, ram_rdata, rd_val;

  logic             in_acc;
  fccm_pkg::mode_e  in_mode;
  fccm_pkg::addr_t  in_clst, in_pclst;
  fccm_pkg::entry_t in_val;
  fccm_pkg::count_t scan_n, iss_inc;
  fccm_pkg::addr_t  start_p;
  logic             found, walk_stop;

  fccm_ram #(
    .WIDTH (fccm_pkg::ENTRY_WIDTH),
    .DEPTH (fccm_pkg::TABLE_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid_i & s_axis_tready_o;
  assign in_mode  = fccm_pkg::mode_e'(s_axis_tuser_i);
  assign in_clst  = s_axis_tdata_i[11:0];
  assign in_pclst = s_axis_tdata_i[23:12];
  assign in_val   = s_axis_tdata_i[39:24];

  assign rd_val  = fwd_q ? '0 : ram_rdata;
  assign scan_n  = lc_q - fccm_pkg::count_t'(fccm_pkg::FIRST_DATA);
  assign iss_inc = {1'b0, iss_p_q} + fccm_pkg::count_t'(1);
  assign start_p = (scan_q < fccm_pkg::FIRST_DATA || {1'b0, scan_q} >= lc_q)
                   ? fccm_pkg::FIRST_DATA : scan_q;
  assign found   = chk_vld_q && (rd_val == '0);
  assign walk_stop = (rd_val == fccm_pkg::END_OF_CHAIN) || (rd_val == '0) ||
                     (32'(rd_val) >= fccm_pkg::TABLE_DEPTH);

  always_comb begin
    lc_d = lc_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i < fccm_pkg::LAST_MIN) begin
        lc_d = fccm_pkg::LAST_MIN;
      end else if (cfg_wdata_i > fccm_pkg::LAST_MAX) begin
        lc_d = fccm_pkg::LAST_MAX;
      end else begin
        lc_d = cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    clr_d     = clr_q;
    iss_p_d   = iss_p_q;
    iss_cnt_d = iss_cnt_q;
    chk_p_d   = chk_p_q;
    chk_vld_d = 1'b0;
    p_d       = p_q;
    walk_d    = walk_q;
    fwd_d     = 1'b0;
    clst_d    = clst_q;
    pclst_d   = pclst_q;
    res_d     = res_q;
    stat_d    = stat_q;
    ram_we    = 1'b0;
    ram_waddr = clst_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = in_clst;
    mvalid_d  = mvalid_q & ~m_axis_tready_i;
    mdata_d   = mdata_q;
    mstat_d   = mstat_q;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + fccm_pkg::addr_t'(1);
        if (clr_q == fccm_pkg::addr_t'(fccm_pkg::TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          clst_d  = in_clst;
          pclst_d = in_pclst;
          res_d   = '0;
          stat_d  = 1'b0;
          case (in_mode)
            fccm_pkg::MODE_CREATE: begin
              iss_p_d   = start_p;
              iss_cnt_d = '0;
              state_d   = S_SCAN;
            end
            fccm_pkg::MODE_REMOVE: begin
              ram_re  = 1'b1;
              walk_d  = in_clst;
              state_d = S_RM_WALK;
            end
            fccm_pkg::MODE_READ: begin
              ram_re  = 1'b1;
              state_d = S_READ;
            end
            fccm_pkg::MODE_WRITE: begin
              ram_we    = 1'b1;
              ram_waddr = in_clst;
              ram_wdata = in_val;
              state_d   = S_WRITE;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        state_d = S_DONE;
      end
      S_SCAN: begin
        if (found) begin
          p_d     = chk_p_q;
          state_d = S_LINK;
        end else if (iss_cnt_q < scan_n) begin
          ram_re    = 1'b1;
          ram_raddr = iss_p_q;
          chk_p_d   = iss_p_q;
          chk_vld_d = 1'b1;
          iss_cnt_d = iss_cnt_q + fccm_pkg::count_t'(1);
          iss_p_d   = (iss_inc >= lc_q) ? fccm_pkg::FIRST_DATA : iss_inc[11:0];
        end else if (!chk_vld_q) begin
          res_d   = '0;
          stat_d  = 1'b1;
          state_d = S_DONE;
        end
      end
      S_LINK: begin
        ram_we    = (clst_q != '0);
        ram_waddr = clst_q;
        ram_wdata = fccm_pkg::entry_t'(p_q);
        state_d   = S_MARK;
      end
      S_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = p_q;
        ram_wdata = fccm_pkg::END_OF_CHAIN;
        scan_d    = p_q;
        res_d     = fccm_pkg::entry_t'(p_q);
        stat_d    = 1'b0;
        state_d   = S_DONE;
      end
      S_RM_WALK: begin
        ram_we    = 1'b1;
        ram_waddr = walk_q;
        ram_wdata = '0;
        if (walk_stop) begin
          state_d = (pclst_q != '0) ? S_RM_PREV : S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = rd_val[11:0];
          walk_d    = rd_val[11:0];
          fwd_d     = (rd_val[11:0] == walk_q);
        end
      end
      S_RM_PREV: begin
        ram_we    = 1'b1;
        ram_waddr = pclst_q;
        ram_wdata = fccm_pkg::END_OF_CHAIN;
        state_d   = S_DONE;
      end
      S_READ: begin
        res_d   = rd_val;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!mvalid_q || m_axis_tready_i) begin
          mvalid_d = 1'b1;
          mdata_d  = res_q;
          mstat_d  = stat_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      lc_q      <= fccm_pkg::LAST_MAX;
      scan_q    <= fccm_pkg::FIRST_DATA;
      clr_q     <= '0;
      chk_vld_q <= 1'b0;
      fwd_q     <= 1'b0;
      mvalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      lc_q      <= lc_d;
      scan_q    <= scan_d;
      clr_q     <= clr_d;
      chk_vld_q <= chk_vld_d;
      fwd_q     <= fwd_d;
      mvalid_q  <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_p_q   <= iss_p_d;
    iss_cnt_q <= iss_cnt_d;
    chk_p_q   <= chk_p_d;
    p_q       <= p_d;
    walk_q    <= walk_d;
    clst_q    <= clst_d;
    pclst_q   <= pclst_d;
    res_q     <= res_d;
    stat_q    <= stat_d;
    mdata_q   <= mdata_d;
    mstat_q   <= mstat_d;
  end

  assign m_axis_tvalid_o   = mvalid_q;
  assign m_axis_tdata_o    = mdata_q;
  assign m_axis_tuser_o[0] = mstat_q;

  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !ram_we)
    else $error("link table written during a free scan");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && ram_re) |->
      (iss_p_q >= fccm_pkg::FIRST_DATA && {1'b0, iss_p_q} < lc_q))
    else $error("free scan reads outside the data clusters");

  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (iss_cnt_q <= scan_n))
    else $error("free scan visited more entries than exist");

  a_alloc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK) |->
      (p_q >= fccm_pkg::FIRST_DATA && {1'b0, p_q} < lc_q))
    else $error("allocated cluster outside the data clusters");

  a_done_after_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && state_d == S_DONE) |-> (stat_d && res_d == '0))
    else $error("scan ended without a free cluster but reported success");

endmodule

@@ tb/tb_fat_cluster_chain_manager_core.sv @@
// Self-checking testbench for fat_cluster_chain_manager_core: random and directed command words
// are checked against a scoreboard that keeps its own copy of the link table and the scan pointer.
// Depends on fccm_pkg and the design files only.
`timescale 1ns / 1ps

module tb_fat_cluster_chain_manager_core;

  typedef struct packed {
    fccm_pkg::entry_t cluster;
    logic             status;
  } result_t;

  typedef struct {
    fccm_pkg::mode_e  mode;
    fccm_pkg::addr_t  cluster;
    fccm_pkg::addr_t  prev;
    fccm_pkg::entry_t value;
  } command_t;

  typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_MOSTLY, RDY_SPARSE} ready_pattern_e;

  class chain_scoreboard;
    fccm_pkg::entry_t link_tbl [fccm_pkg::TABLE_DEPTH];
    int               scan_ptr;
    fccm_pkg::count_t last_cl;
    result_t          pending_results [$];
    int               errors;

    function new();
      foreach (link_tbl[i]) link_tbl[i] = '0;
      scan_ptr = int'(fccm_pkg::FIRST_DATA);
      last_cl  = fccm_pkg::LAST_MAX;
      errors   = 0;
    endfunction

    function void set_last(fccm_pkg::count_t v);
      last_cl = v;
    endfunction

    function void flag(string field, fccm_pkg::entry_t want, fccm_pkg::entry_t got);
      errors++;
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
    endfunction

    function result_t note_command(fccm_pkg::mode_e m, fccm_pkg::addr_t c, fccm_pkg::addr_t p,
                                   fccm_pkg::entry_t v);
      result_t          r;
      int               lc;
      int               pos;
      fccm_pkg::entry_t nxt;
      bit               found;
      r     = '0;
      found = 1'b0;
      case (m)
        fccm_pkg::MODE_CREATE: begin
          lc = int'(last_cl);
          if (lc < int'(fccm_pkg::LAST_MIN)) lc = int'(fccm_pkg::LAST_MIN);
          if (lc > int'(fccm_pkg::LAST_MAX)) lc = int'(fccm_pkg::LAST_MAX);
          pos = scan_ptr;
          if (pos < int'(fccm_pkg::FIRST_DATA) || pos >= lc) pos = int'(fccm_pkg::FIRST_DATA);
          for (int i = 0; i < lc - int'(fccm_pkg::FIRST_DATA) && !found; i++) begin
            if (link_tbl[pos] == '0) begin
              found = 1'b1;
            end else begin
              pos++;
              if (pos >= lc) pos = int'(fccm_pkg::FIRST_DATA);
            end
          end
          if (found) begin
            if (c != '0) link_tbl[c] = fccm_pkg::entry_t'(pos);
            link_tbl[pos] = fccm_pkg::END_OF_CHAIN;
            scan_ptr      = pos;
            r.cluster     = fccm_pkg::entry_t'(pos);
          end else begin
            r.status = 1'b1;
          end
        end
        fccm_pkg::MODE_REMOVE: begin
          pos = int'(c);
          for (int walk = 0; walk < int'(fccm_pkg::TABLE_DEPTH); walk++) begin
            nxt           = link_tbl[pos];
            link_tbl[pos] = '0;
            if (nxt == fccm_pkg::END_OF_CHAIN || nxt == '0 || nxt >= fccm_pkg::TABLE_DEPTH) break;
            pos = int'(nxt);
          end
          if (p != '0) link_tbl[p] = fccm_pkg::END_OF_CHAIN;
        end
        fccm_pkg::MODE_READ: begin
          r.cluster = link_tbl[c];
        end
        default: begin
          link_tbl[c] = v;
        end
      endcase
      pending_results.push_back(r);
      return r;
    endfunction

    function void check_result(fccm_pkg::entry_t cl, logic st);
      result_t want;
      if (pending_results.size() == 0) begin
        flag("no word pending, result_cluster", '0, cl);
        return;
      end
      want = pending_results.pop_front();
      if (cl !== want.cluster) flag("result_cluster", want.cluster, cl);
      if (st !== want.status) begin
        flag("status", fccm_pkg::entry_t'(want.status), fccm_pkg::entry_t'(st));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [12:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_axis_tvalid_o;
  logic        m_tready = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  chain_scoreboard sb = new();

  fccm_pkg::addr_t chain_head [$];
  fccm_pkg::addr_t chain_tail [$];
  int              burst_left = 0;
  bit              steady = 1'b0;
  int              hold_left = 0;
  ready_pattern_e  rdy_kind = RDY_ALWAYS;
  int              rdy_left = 0;

  fat_cluster_chain_manager_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o[0]);
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      if (rdy_left == 0) begin
        rdy_kind = ready_pattern_e'($urandom_range(3));
        rdy_left = $urandom_range(256, 32);
      end
      rdy_left--;
      case (rdy_kind)
        RDY_ALWAYS: m_tready <= 1'b1;
        RDY_HALF:   m_tready <= 1'($urandom_range(1));
        RDY_MOSTLY: m_tready <= ($urandom_range(9) != 0);
        default:    m_tready <= (rdy_left % 5 == 0);
      endcase
    end
  end

  task automatic send_word(input fccm_pkg::mode_e m, input fccm_pkg::addr_t c,
                           input fccm_pkg::addr_t p, input fccm_pkg::entry_t v,
                           output result_t r);
    s_tuser  <= m;
    s_tdata  <= {v, p, c};
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = sb.note_command(m, c, p, v);
    @(negedge clk_i);
  endtask

  task automatic pace();
    int gap;
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(40, 0);
    gap = ($urandom_range(7) == 0) ? $urandom_range(30, 8) : $urandom_range(4, 1);
    s_tvalid <= 1'b0;
    repeat (gap) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_last_cluster(input fccm_pkg::count_t v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    sb.set_last(v);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_words(input int count);
    fccm_pkg::mode_e  m;
    fccm_pkg::addr_t  c;
    fccm_pkg::addr_t  p;
    fccm_pkg::entry_t v;
    result_t          r;
    int               pick;
    int               roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (chain_head.size() > 40 && roll < 35) roll = 40;
      p    = '0;
      v    = fccm_pkg::entry_t'($urandom);
      pick = -1;
      if (roll < 35) begin
        m = fccm_pkg::MODE_CREATE;
        c = '0;
        if (chain_tail.size() > 0 && $urandom_range(1) == 1) begin
          pick = $urandom_range(chain_tail.size() - 1);
          c    = chain_tail[pick];
        end
      end else if (roll < 50) begin
        m = fccm_pkg::MODE_REMOVE;
        c = fccm_pkg::addr_t'($urandom);
        if (chain_head.size() > 0 && $urandom_range(9) != 0) begin
          pick = $urandom_range(chain_head.size() - 1);
          c    = chain_head[pick];
        end
        if ($urandom_range(3) == 0) p = fccm_pkg::addr_t'($urandom);
      end else if (roll < 72) begin
        m = fccm_pkg::MODE_READ;
        c = fccm_pkg::addr_t'($urandom);
        if (chain_tail.size() > 0 && $urandom_range(1) == 1) begin
          c = chain_tail[$urandom_range(chain_tail.size() - 1)];
        end
      end else if (roll < 88) begin
        m = fccm_pkg::MODE_WRITE;
        c = fccm_pkg::addr_t'($urandom);
        case ($urandom_range(3))
          0:       v = '0;
          1:       v = fccm_pkg::END_OF_CHAIN;
          2:       v = fccm_pkg::entry_t'($urandom_range(fccm_pkg::TABLE_DEPTH - 1));
          default: v = fccm_pkg::entry_t'($urandom);
        endcase
      end else begin
        m = fccm_pkg::MODE_CREATE;
        c = fccm_pkg::addr_t'($urandom);
      end
      send_word(m, c, p, v, r);
      if (roll < 35 && !r.status) begin
        if (pick < 0) begin
          chain_head.push_back(fccm_pkg::addr_t'(r.cluster));
          chain_tail.push_back(fccm_pkg::addr_t'(r.cluster));
        end else begin
          chain_tail[pick] = fccm_pkg::addr_t'(r.cluster);
        end
      end
      if (m == fccm_pkg::MODE_REMOVE && pick >= 0) begin
        chain_head.delete(pick);
        chain_tail.delete(pick);
      end
      if ($urandom_range(149) == 0) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end else begin
        pace();
      end
    end
  endtask

  initial begin
    command_t         directed_cmds [$];
    fccm_pkg::count_t cfg_plan [$];
    result_t          r;
    directed_cmds = '{
      '{fccm_pkg::MODE_READ,   12'd0,    12'd0,    16'h0000},
      '{fccm_pkg::MODE_READ,   12'd4095, 12'd0,    16'h0000},
      '{fccm_pkg::MODE_CREATE, 12'd0,    12'd0,    16'h0000},
      '{fccm_pkg::MODE_CREATE, 12'd2,    12'd0,    16'h0000},
      '{fccm_pkg::MODE_CREATE, 12'd3,    12'd0,    16'h0000},
      '{fccm_pkg::MODE_READ,   12'd2,    12'd0,    16'h0000},
      '{fccm_pkg::MODE_REMOVE, 12'd2,    12'd3,    16'h0000},
      '{fccm_pkg::MODE_CREATE, 12'd4,    12'd0,    16'h0000},
      '{fccm_pkg::MODE_WRITE,  12'd4095, 12'd0,    16'hFFFF},
      '{fccm_pkg::MODE_WRITE,  12'd0,    12'd0,    16'h1234},
      '{fccm_pkg::MODE_READ,   12'd0,    12'd0,    16'h0000},
      '{fccm_pkg::MODE_WRITE,  12'd10,   12'd0,    16'h1000},
      '{fccm_pkg::MODE_WRITE,  12'd11,   12'd0,    16'h000A},
      '{fccm_pkg::MODE_REMOVE, 12'd11,   12'd0,    16'h0000},
      '{fccm_pkg::MODE_WRITE,  12'd20,   12'd0,    16'h0015},
      '{fccm_pkg::MODE_WRITE,  12'd21,   12'd0,    16'h0014},
      '{fccm_pkg::MODE_REMOVE, 12'd20,   12'd4095, 16'h0000},
      '{fccm_pkg::MODE_REMOVE, 12'd0,    12'd0,    16'h0000},
      '{fccm_pkg::MODE_READ,   12'd4095, 12'd0,    16'h0000},
      '{fccm_pkg::MODE_CREATE, 12'd4095, 12'd0,    16'h0000},
      '{fccm_pkg::MODE_READ,   12'd4095, 12'd0,    16'h0000},
      '{fccm_pkg::MODE_WRITE,  12'd4095, 12'd0,    16'h0000},
      '{fccm_pkg::MODE_WRITE,  12'd3,    12'd0,    16'h0000},
      '{fccm_pkg::MODE_READ,   12'd3,    12'd0,    16'h0000}
    };
    cfg_plan = '{13'd3, 13'd0, 13'd8, 13'd2, 13'd64, 13'd4096, 13'd1, 13'd17, 13'd8191,
                 13'd200, 13'd4097, 13'd5, 13'd4096};

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_last_cluster(fccm_pkg::LAST_MAX);

    foreach (directed_cmds[i]) begin
      send_word(directed_cmds[i].mode, directed_cmds[i].cluster, directed_cmds[i].prev,
                directed_cmds[i].value, r);
      pace();
    end

    foreach (cfg_plan[k]) begin
      s_tvalid <= 1'b0;
      wait_drained();
      repeat (16) @(negedge clk_i);
      write_last_cluster(cfg_plan[k]);
      if (cfg_plan[k] == 13'd64) begin
        // The receiver stalls long enough for the block to fill up and refuse words.
        steady    = 1'b1;
        hold_left = 300;
        random_words(60);
        steady    = 1'b0;
        random_words(80);
      end else begin
        random_words(140);
      end
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (64) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb_fat_cluster_chain_manager_core: PASS");
    end else begin
      $display("tb_fat_cluster_chain_manager_core: FAIL");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb_fat_cluster_chain_manager_core: FAIL");
    $finish;
  end

endmodule
